[hw/rtl/thjp_pkg.sv]
// shared types, constants and lookup functions for the tensor header parser
`default_nettype none
package thjp_pkg;

  localparam int unsigned MaxRank       = 8;
  localparam int unsigned MaxTensors    = 65536;
  localparam int unsigned SkipDepthBits = 16;
  localparam int unsigned TcntBits      = 17;

  typedef enum logic [4:0] {
    PH_START, PH_TOP_KEY_OR_END, PH_TOP_KEY, PH_TOP_COLON, PH_T_OPEN,
    PH_T_KEY_OR_END, PH_T_KEY, PH_T_COLON, PH_DTYPE_OPEN, PH_DTYPE_STR,
    PH_SHAPE_OPEN, PH_SHAPE_FIRST, PH_SHAPE_NUM, PH_SHAPE_SEP, PH_SHAPE_ELEM,
    PH_SHAPE_FULL, PH_OFF_OPEN, PH_OFF_A_PRE, PH_OFF_A, PH_OFF_COMMA,
    PH_OFF_B_PRE, PH_OFF_B, PH_OFF_CLOSE, PH_T_AFTER, PH_TOP_AFTER,
    PH_SKIP_START, PH_SKIP_SCALAR, PH_SKIP_STR, PH_SKIP_NEST, PH_SKIP_NEST_STR,
    PH_DONE, PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    K_NAME = 3'd0, K_META = 3'd1, K_DIM = 3'd2, K_REC = 3'd3, K_DONE = 3'd4,
    K_ERR = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    E_NONE = 4'd0, E_NOT_OBJ = 4'd1, E_UNEXP = 4'd2, E_ESC = 4'd3, E_END = 4'd4,
    E_NO_DIGIT = 4'd5, E_RANK = 4'd6, E_MISSING = 4'd7, E_REVERSED = 4'd8,
    E_RANGE = 4'd9, E_DEPTH = 4'd10, E_TOO_MANY = 4'd11
  } err_t;

  localparam logic [3:0] DtypeUnknown = 4'd13;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  name_byte;
    logic [15:0] tensor_index;
    logic [2:0]  dim_index;
    logic [63:0] dim_value;
    logic [3:0]  dtype_code;
    logic [3:0]  element_bytes;
    logic [3:0]  rank;
    logic [63:0] data_start;
    logic [63:0] data_bytes;
    logic [3:0]  error_code;
  } result_t;

  // key character at position p for key i, zero past the end
  function automatic logic [7:0] key_char(input logic [1:0] i, input logic [3:0] p);
    logic [95:0] s;
    logic [3:0]  n;
    begin
      case (i)
        2'd0: begin s = "__metadata__"; n = 4'd12; end
        2'd1: begin s = {56'd0, "dtype"}; n = 4'd5; end
        2'd2: begin s = {56'd0, "shape"}; n = 4'd5; end
        default: begin s = {"data_", "offsets"}; n = 4'd12; end
      endcase
      if (p >= n) key_char = 8'd0;
      else key_char = s[(n - p - 4'd1) * 8 +: 8];
    end
  endfunction

  function automatic logic [3:0] key_len(input logic [1:0] i);
    case (i)
      2'd0: key_len = 4'd12;
      2'd1: key_len = 4'd5;
      2'd2: key_len = 4'd5;
      default: key_len = 4'd12;
    endcase
  endfunction

  function automatic logic [7:0] dtype_char(input logic [3:0] i, input logic [2:0] p);
    logic [31:0] s;
    logic [2:0]  n;
    begin
      case (i)
        4'd0: begin s = {8'd0, "F64"}; n = 3'd3; end
        4'd1: begin s = {8'd0, "F32"}; n = 3'd3; end
        4'd2: begin s = {8'd0, "F16"}; n = 3'd3; end
        4'd3: begin s = "BF16"; n = 3'd4; end
        4'd4: begin s = {8'd0, "I64"}; n = 3'd3; end
        4'd5: begin s = {8'd0, "I32"}; n = 3'd3; end
        4'd6: begin s = {8'd0, "I16"}; n = 3'd3; end
        4'd7: begin s = {16'd0, "I8"}; n = 3'd2; end
        4'd8: begin s = {8'd0, "U64"}; n = 3'd3; end
        4'd9: begin s = {8'd0, "U32"}; n = 3'd3; end
        4'd10: begin s = {8'd0, "U16"}; n = 3'd3; end
        4'd11: begin s = {16'd0, "U8"}; n = 3'd2; end
        default: begin s = "BOOL"; n = 3'd4; end
      endcase
      if (p >= n) dtype_char = 8'd0;
      else dtype_char = s[(n - p - 3'd1) * 8 +: 8];
    end
  endfunction

  function automatic logic [2:0] dtype_len(input logic [3:0] i);
    case (i)
      4'd3, 4'd12: dtype_len = 3'd4;
      4'd7, 4'd11: dtype_len = 3'd2;
      default:     dtype_len = 3'd3;
    endcase
  endfunction

  function automatic logic [3:0] dtype_size(input logic [3:0] i);
    case (i)
      4'd0, 4'd4, 4'd8:         dtype_size = 4'd8;
      4'd1, 4'd5, 4'd9:         dtype_size = 4'd4;
      4'd2, 4'd3, 4'd6, 4'd10:  dtype_size = 4'd2;
      4'd7, 4'd11, 4'd12:       dtype_size = 4'd1;
      default:                  dtype_size = 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tensor_header_json_parser.sv]
// top level: byte-serial safetensors header parser with output register
// A result is registered and appears the cycle after its byte is accepted.
// Throughput: one byte per cycle unless out_ready stalls, each in a single
//   pass via phase logic, 64-bit times-ten accumulator and offset compares.
// Reset (rst_n low, synchronous): parser waits for the opening brace, the
//   region size register clears, and the output register empties.
`default_nettype none
module tensor_header_json_parser import thjp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_header_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_name_byte,
  output logic [15:0]      out_tensor_index,
  output logic [2:0]       out_dim_index,
  output logic [63:0]      out_dim_value,
  output logic [3:0]       out_dtype_code,
  output logic [3:0]       out_element_bytes,
  output logic [3:0]       out_rank,
  output logic [63:0]      out_data_start,
  output logic [63:0]      out_data_bytes,
  output logic [3:0]       out_error_code
);
  phase_t ph_r, ph_nxt, ret_r, ret_nxt;
  logic [3:0]  kf_r, kf_nxt, kp_r, kp_nxt;
  logic [12:0] df_r, df_nxt;
  logic [2:0]  dp_r, dp_nxt;
  logic [63:0] acc_r, acc_nxt, st_r, st_nxt, en_r, en_nxt, region_r;
  logic [3:0]  dt_r, dt_nxt, rk_r, rk_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [SkipDepthBits-1:0] dep_r, dep_nxt;
  logic        bk_r, bk_nxt;
  logic [TcntBits-1:0] tc_r, tc_nxt;
  result_t res, out_r;
  logic        rv, ov_r;
  logic        take;

  // matcher inputs follow the cleared state on a first byte
  logic [3:0]  m_kf, m_kp, kf_fed, kp_fed, khit, dcode;
  logic [12:0] m_df, df_fed;
  logic [2:0]  m_dp, dp_fed;

  assign in_ready = !ov_r || out_ready;
  assign take = in_valid && in_ready;

  assign m_kf = in_first_byte ? 4'hF : kf_r;
  assign m_kp = in_first_byte ? 4'd0 : kp_r;
  assign m_df = in_first_byte ? 13'h1FFF : df_r;
  assign m_dp = in_first_byte ? 3'd0 : dp_r;

  thjp_matcher u_match (
    .c(in_header_byte), .key_flags(m_kf), .key_pos(m_kp), .dt_flags(m_df),
    .dt_pos(m_dp), .key_flags_fed(kf_fed), .key_pos_fed(kp_fed), .key_hit(khit),
    .dt_flags_fed(df_fed), .dt_pos_fed(dp_fed), .dt_code(dcode)
  );

  // per-byte parse step
  always_comb begin
    logic [7:0]  c;
    logic        ws, dig, redo;
    logic [63:0] dval, acc10;
    phase_t      p;
    c = in_header_byte;
    ph_nxt = ph_r; ret_nxt = ret_r; kf_nxt = kf_r; kp_nxt = kp_r;
    df_nxt = df_r; dp_nxt = dp_r; acc_nxt = acc_r; st_nxt = st_r; en_nxt = en_r;
    dt_nxt = dt_r; rk_nxt = rk_r; seen_nxt = seen_r; dep_nxt = dep_r;
    bk_nxt = bk_r; tc_nxt = tc_r;
    if (in_first_byte) begin
      ph_nxt = PH_START; ret_nxt = PH_TOP_AFTER; kf_nxt = 4'hF; kp_nxt = '0;
      df_nxt = 13'h1FFF; dp_nxt = '0; acc_nxt = '0; st_nxt = '0; en_nxt = '0;
      dt_nxt = '0; rk_nxt = '0; seen_nxt = '0; dep_nxt = '0; bk_nxt = 1'b0;
      tc_nxt = '0;
    end
    res = '0; rv = 1'b0; redo = 1'b0;
    ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    dig = (c >= "0") && (c <= "9");
    dval = {60'd0, 4'(c - "0")};
    acc10 = (acc_nxt << 3) + (acc_nxt << 1) + dval;
    p = ph_nxt;

    // number and skip end phases first hand the byte on to the following phase
    case (p)
      PH_SHAPE_NUM: begin
        if (dig) acc_nxt = acc10;
        else begin
          rv = 1'b1; res.kind = K_DIM; res.tensor_index = tc_nxt[15:0];
          res.dim_index = rk_nxt[2:0]; res.dim_value = acc_nxt;
          rk_nxt = rk_nxt + 4'd1; p = PH_SHAPE_SEP; redo = 1'b1;
        end
      end
      PH_OFF_A: begin
        if (dig) acc_nxt = acc10;
        else begin st_nxt = acc_nxt; p = PH_OFF_COMMA; redo = 1'b1; end
      end
      PH_OFF_B: begin
        if (dig) acc_nxt = acc10;
        else begin en_nxt = acc_nxt; p = PH_OFF_CLOSE; redo = 1'b1; end
      end
      PH_SKIP_SCALAR: begin
        if (c == "," || c == "]" || c == "}" || ws) begin p = ret_nxt; redo = 1'b1; end
      end
      PH_SKIP_START: begin
        if (c == "," || c == "]" || c == "}") begin p = ret_nxt; redo = 1'b1; end
      end
      default: ;
    endcase
    ph_nxt = p;

    if (redo || (p != PH_SHAPE_NUM && p != PH_OFF_A && p != PH_OFF_B &&
                 p != PH_SKIP_SCALAR)) begin
      case (p)
        PH_START: if (!ws) begin
          if (c == "{") ph_nxt = PH_TOP_KEY_OR_END;
          else begin rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_NOT_OBJ; ph_nxt = PH_ERR; end
        end
        PH_TOP_KEY_OR_END, PH_TOP_AFTER: if (!ws) begin
          if (c == "}") begin rv = 1'b1; res.kind = K_DONE; ph_nxt = PH_DONE; end
          else if (c == "," && p == PH_TOP_AFTER) ph_nxt = PH_TOP_KEY_OR_END;
          else if (c == "\"" && p == PH_TOP_KEY_OR_END) begin
            kf_nxt = 4'h1; kp_nxt = '0; ph_nxt = PH_TOP_KEY;
          end else begin rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_TOP_KEY: begin
          if (c == "\"") begin
            if (khit[0]) begin rv = 1'b1; res.kind = K_META; res.tensor_index = tc_nxt[15:0]; end
            ph_nxt = PH_TOP_COLON;
          end else if (c == "\\") begin
            rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_ESC; ph_nxt = PH_ERR;
          end else begin
            kf_nxt = kf_fed; kp_nxt = kp_fed; rv = 1'b1; res.kind = K_NAME;
            res.name_byte = c; res.tensor_index = tc_nxt[15:0];
          end
        end
        PH_TOP_COLON: if (!ws) begin
          if (c != ":") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
          else if (khit[0]) begin ret_nxt = PH_TOP_AFTER; ph_nxt = PH_SKIP_START; end
          else if (tc_nxt >= TcntBits'(MaxTensors)) begin
            rv = 1'b1; res.kind = K_ERR; res.error_code = E_TOO_MANY; ph_nxt = PH_ERR;
          end else begin
            seen_nxt = '0; dt_nxt = '0; rk_nxt = '0; st_nxt = '0; en_nxt = '0;
            ph_nxt = PH_T_OPEN;
          end
        end
        PH_T_OPEN: if (!ws) begin
          if (c == "{") ph_nxt = PH_T_KEY_OR_END;
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_T_KEY_OR_END, PH_T_AFTER: if (!ws) begin
          if (c == "}") begin
            rv = 1'b1;
            if (seen_nxt != 3'd7) begin res.kind = K_ERR; res.error_code = E_MISSING; ph_nxt = PH_ERR; end
            else if (en_nxt < st_nxt) begin res.kind = K_ERR; res.error_code = E_REVERSED; ph_nxt = PH_ERR; end
            else if (en_nxt > region_r) begin res.kind = K_ERR; res.error_code = E_RANGE; ph_nxt = PH_ERR; end
            else begin
              res.kind = K_REC; res.tensor_index = tc_nxt[15:0]; res.dtype_code = dt_nxt;
              res.element_bytes = dtype_size(dt_nxt); res.rank = rk_nxt;
              res.data_start = st_nxt; res.data_bytes = en_nxt - st_nxt;
              tc_nxt = tc_nxt + 1'b1; ph_nxt = PH_TOP_AFTER;
            end
          end else if (c == "," && p == PH_T_AFTER) ph_nxt = PH_T_KEY_OR_END;
          else if (c == "\"" && p == PH_T_KEY_OR_END) begin
            kf_nxt = 4'hE; kp_nxt = '0; ph_nxt = PH_T_KEY;
          end else begin rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_T_KEY: begin
          if (c == "\"") ph_nxt = PH_T_COLON;
          else if (c == "\\") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_ESC; ph_nxt = PH_ERR; end
          else begin kf_nxt = kf_fed; kp_nxt = kp_fed; end
        end
        PH_T_COLON: if (!ws) begin
          if (c != ":") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
          else if (khit[1]) ph_nxt = PH_DTYPE_OPEN;
          else if (khit[2]) ph_nxt = PH_SHAPE_OPEN;
          else if (khit[3]) ph_nxt = PH_OFF_OPEN;
          else begin ret_nxt = PH_T_AFTER; ph_nxt = PH_SKIP_START; end
        end
        PH_DTYPE_OPEN: if (!ws) begin
          if (c == "\"") begin df_nxt = 13'h1FFF; dp_nxt = '0; ph_nxt = PH_DTYPE_STR; end
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_DTYPE_STR: begin
          if (c == "\"") begin dt_nxt = dcode; seen_nxt[0] = 1'b1; ph_nxt = PH_T_AFTER; end
          else if (c == "\\") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_ESC; ph_nxt = PH_ERR; end
          else begin df_nxt = df_fed; dp_nxt = dp_fed; end
        end
        PH_SHAPE_OPEN: if (!ws) begin
          if (c == "[") begin rk_nxt = '0; ph_nxt = PH_SHAPE_FIRST; end
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_SHAPE_FIRST, PH_SHAPE_ELEM, PH_OFF_A_PRE, PH_OFF_B_PRE: if (!ws) begin
          if (c == "]" && p == PH_SHAPE_FIRST) begin seen_nxt[1] = 1'b1; ph_nxt = PH_T_AFTER; end
          else if (dig) begin
            acc_nxt = dval;
            ph_nxt = (p == PH_OFF_A_PRE) ? PH_OFF_A : (p == PH_OFF_B_PRE) ? PH_OFF_B : PH_SHAPE_NUM;
          end else begin rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_NO_DIGIT; ph_nxt = PH_ERR; end
        end
        PH_SHAPE_SEP: if (!ws) begin
          if (c == ",") ph_nxt = (rk_nxt >= 4'(MaxRank)) ? PH_SHAPE_FULL : PH_SHAPE_ELEM;
          else if (c == "]") begin seen_nxt[1] = 1'b1; ph_nxt = PH_T_AFTER; end
          else begin rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_SHAPE_FULL: begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_RANK; ph_nxt = PH_ERR; end
        PH_OFF_OPEN: if (!ws) begin
          if (c == "[") ph_nxt = PH_OFF_A_PRE;
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_OFF_COMMA: if (!ws) begin
          if (c == ",") ph_nxt = PH_OFF_B_PRE;
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_OFF_CLOSE: if (!ws) begin
          if (c == "]") begin seen_nxt[2] = 1'b1; ph_nxt = PH_T_AFTER; end
          else begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_UNEXP; ph_nxt = PH_ERR; end
        end
        PH_SKIP_START: if (!ws) begin
          if (c == "{" || c == "[") begin
            bk_nxt = (c == "["); dep_nxt = SkipDepthBits'(1); ph_nxt = PH_SKIP_NEST;
          end else if (c == "\"") ph_nxt = PH_SKIP_STR;
          else ph_nxt = PH_SKIP_SCALAR;
        end
        PH_SKIP_STR: begin
          if (c == "\"") ph_nxt = ret_nxt;
          else if (c == "\\") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_ESC; ph_nxt = PH_ERR; end
        end
        PH_SKIP_NEST: begin
          if (c == "\"") ph_nxt = PH_SKIP_NEST_STR;
          else if (c == (bk_nxt ? "[" : "{")) begin
            if (&dep_nxt) begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_DEPTH; ph_nxt = PH_ERR; end
            else dep_nxt = dep_nxt + 1'b1;
          end else if (c == (bk_nxt ? "]" : "}")) begin
            dep_nxt = dep_nxt - 1'b1;
            if (dep_nxt == '0) ph_nxt = ret_nxt;
          end
        end
        PH_SKIP_NEST_STR: begin
          if (c == "\"") ph_nxt = PH_SKIP_NEST;
          else if (c == "\\") begin rv = 1'b1; res.kind = K_ERR; res.error_code = E_ESC; ph_nxt = PH_ERR; end
        end
        default: ;
      endcase
    end

    // end of input while still parsing
    if (in_last_byte && ph_nxt != PH_DONE && ph_nxt != PH_ERR) begin
      rv = 1'b1; res = '0; res.kind = K_ERR; res.error_code = E_END; ph_nxt = PH_ERR;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_START; ret_r <= PH_TOP_AFTER; kf_r <= 4'hF; kp_r <= '0;
      df_r <= 13'h1FFF; dp_r <= '0; acc_r <= '0; st_r <= '0; en_r <= '0;
      dt_r <= '0; rk_r <= '0; seen_r <= '0; dep_r <= '0; bk_r <= 1'b0; tc_r <= '0;
      region_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) region_r <= cfg_wdata;
      if (take) begin
        ph_r <= ph_nxt; ret_r <= ret_nxt; kf_r <= kf_nxt; kp_r <= kp_nxt;
        df_r <= df_nxt; dp_r <= dp_nxt; acc_r <= acc_nxt; st_r <= st_nxt;
        en_r <= en_nxt; dt_r <= dt_nxt; rk_r <= rk_nxt; seen_r <= seen_nxt;
        dep_r <= dep_nxt; bk_r <= bk_nxt; tc_r <= tc_nxt;
      end
      if (take) ov_r <= rv;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && rv) out_r <= res;
  end

  assign out_valid = ov_r;
  assign out_kind = out_r.kind;
  assign out_name_byte = out_r.name_byte;
  assign out_tensor_index = out_r.tensor_index;
  assign out_dim_index = out_r.dim_index;
  assign out_dim_value = out_r.dim_value;
  assign out_dtype_code = out_r.dtype_code;
  assign out_element_bytes = out_r.element_bytes;
  assign out_rank = out_r.rank;
  assign out_data_start = out_r.data_start;
  assign out_data_bytes = out_r.data_bytes;
  assign out_error_code = out_r.error_code;
endmodule
`default_nettype wire

[hw/rtl/thjp_matcher.sv]
// key and dtype string matchers: candidate flags narrowed one character at a time
`default_nettype none
module thjp_matcher import thjp_pkg::*; (
  input  wire logic [7:0]  c,
  input  wire logic [3:0]  key_flags,
  input  wire logic [3:0]  key_pos,
  input  wire logic [12:0] dt_flags,
  input  wire logic [2:0]  dt_pos,
  output logic [3:0]  key_flags_fed,
  output logic [3:0]  key_pos_fed,
  output logic [3:0]  key_hit,
  output logic [12:0] dt_flags_fed,
  output logic [2:0]  dt_pos_fed,
  output logic [3:0]  dt_code
);
  // key candidates
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_flags_fed[i] = key_flags[i] && (key_pos < key_len(2'(i))) &&
                         (c == key_char(2'(i), key_pos));
      key_hit[i] = key_flags[i] && (key_pos == key_len(2'(i)));
    end
    key_pos_fed = (key_pos != 4'd15) ? key_pos + 4'd1 : key_pos;
  end

  // dtype candidates and resolve
  always_comb begin
    dt_code = DtypeUnknown;
    for (int i = 0; i < 13; i++) begin
      dt_flags_fed[i] = dt_flags[i] && (dt_pos < dtype_len(4'(i))) &&
                        (c == dtype_char(4'(i), dt_pos));
    end
    for (int i = 12; i >= 0; i--) begin
      if (dt_flags[i] && dt_pos == dtype_len(4'(i))) dt_code = 4'(i);
    end
    dt_pos_fed = (dt_pos != 3'd7) ? dt_pos + 3'd1 : dt_pos;
  end
endmodule
`default_nettype wire

[tb/header_result_checker.sv]
// checker for the tensor header parser: byte-level prediction and result compare
`timescale 1ns / 100ps
module header_result_checker import thjp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_header_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_kind,
  input  wire logic [7:0]  out_name_byte,
  input  wire logic [15:0] out_tensor_index,
  input  wire logic [2:0]  out_dim_index,
  input  wire logic [63:0] out_dim_value,
  input  wire logic [3:0]  out_dtype_code,
  input  wire logic [3:0]  out_element_bytes,
  input  wire logic [3:0]  out_rank,
  input  wire logic [63:0] out_data_start,
  input  wire logic [63:0] out_data_bytes,
  input  wire logic [3:0]  out_error_code,
  output int               fail_count,
  output int               pending
);

  localparam logic [16:0] DepthCap = 17'd65535;

  string       key_names [4] = '{"__metadata__", "dtype", "shape", {"data_", "offsets"}};
  string       dtype_names [13] = '{"F64", "F32", "F16", "BF16", "I64", "I32", "I16", "I8",
                                    "U64", "U32", "U16", "U8", "BOOL"};
  logic [3:0]  dtype_bytes [13] = '{8, 4, 2, 2, 8, 4, 2, 1, 8, 4, 2, 1, 1};

  // predictor state
  phase_t      phase, skip_back;
  logic [3:0]  key_live, key_pos;
  logic [12:0] dt_live;
  logic [2:0]  dt_pos;
  logic [63:0] accum, span_lo, off_end, region_bytes;
  logic [3:0]  cur_dtype, cur_rank;
  logic [2:0]  fields_seen;
  logic [16:0] nest_depth;
  bit          nest_square;
  int unsigned tensors_done;
  result_t     res;
  bit          res_hit;
  result_t     expected_results [$];

  assign pending = expected_results.size();

  function automatic bit is_space(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic restart_parse();
    phase = PH_START;
    skip_back = PH_TOP_AFTER;
    key_live = 4'hf;
    key_pos = 0;
    dt_live = 13'h1fff;
    dt_pos = 0;
    accum = 0;
    span_lo = 0;
    off_end = 0;
    cur_dtype = 0;
    cur_rank = 0;
    fields_seen = 0;
    nest_depth = 0;
    nest_square = 0;
    tensors_done = 0;
  endtask

  task automatic emit(kind_t k);
    res = '0;
    res.kind = k;
    res_hit = 1;
  endtask

  task automatic raise(err_t e);
    emit(K_ERR);
    res.error_code = e;
    phase = PH_ERR;
  endtask

  // narrow the candidate key set by one character
  task automatic match_key(logic [7:0] c);
    string s;
    for (int i = 0; i < 4; i++) begin
      s = key_names[i];
      if (key_live[i] && (key_pos >= s.len() || c != s[key_pos])) key_live[i] = 0;
    end
    if (key_pos < 15) key_pos++;
  endtask

  function automatic bit key_hit(int i);
    string s;
    s = key_names[i];
    return key_live[i] && key_pos == s.len();
  endfunction

  task automatic match_dtype(logic [7:0] c);
    string s;
    for (int i = 0; i < 13; i++) begin
      s = dtype_names[i];
      if (dt_live[i] && (dt_pos >= s.len() || c != s[dt_pos])) dt_live[i] = 0;
    end
    if (dt_pos < 7) dt_pos++;
  endtask

  function automatic logic [3:0] dtype_pick();
    string s;
    for (int i = 0; i < 13; i++) begin
      s = dtype_names[i];
      if (dt_live[i] && dt_pos == s.len()) return 4'(i);
    end
    return DtypeUnknown;
  endfunction

  // closing brace of a tensor object
  task automatic close_tensor();
    if (fields_seen != 3'd7) raise(E_MISSING);
    else if (off_end < span_lo) raise(E_REVERSED);
    else if (off_end > region_bytes) raise(E_RANGE);
    else begin
      emit(K_REC);
      res.tensor_index = tensors_done[15:0];
      res.dtype_code = cur_dtype;
      res.element_bytes = cur_dtype < 13 ? dtype_bytes[cur_dtype] : 4'd0;
      res.rank = cur_rank;
      res.data_start = span_lo;
      res.data_bytes = off_end - span_lo;
      tensors_done++;
      phase = PH_TOP_AFTER;
    end
  endtask

  // one pass of the phase logic; again asks for the byte to be seen twice
  task automatic parse_byte(logic [7:0] c, output bit again);
    logic [7:0] open_ch, close_ch;
    open_ch = nest_square ? "[" : "{";
    close_ch = nest_square ? "]" : "}";
    again = 0;
    case (phase)
      PH_START: if (!is_space(c)) begin
        if (c == "{") phase = PH_TOP_KEY_OR_END; else raise(E_NOT_OBJ);
      end
      PH_TOP_KEY_OR_END: if (!is_space(c)) begin
        if (c == "}") begin emit(K_DONE); phase = PH_DONE; end
        else if (c == "\"") begin key_live = 4'h1; key_pos = 0; phase = PH_TOP_KEY; end
        else raise(E_UNEXP);
      end
      PH_TOP_KEY: begin
        if (c == "\"") begin
          if (key_hit(0)) begin emit(K_META); res.tensor_index = tensors_done[15:0]; end
          phase = PH_TOP_COLON;
        end else if (c == "\\") raise(E_ESC);
        else begin
          match_key(c);
          emit(K_NAME);
          res.name_byte = c;
          res.tensor_index = tensors_done[15:0];
        end
      end
      PH_TOP_COLON: if (!is_space(c)) begin
        if (c != ":") raise(E_UNEXP);
        else if (key_hit(0)) begin skip_back = PH_TOP_AFTER; phase = PH_SKIP_START; end
        else if (tensors_done >= MaxTensors) raise(E_TOO_MANY);
        else begin
          fields_seen = 0; cur_dtype = 0; cur_rank = 0; span_lo = 0; off_end = 0;
          phase = PH_T_OPEN;
        end
      end
      PH_T_OPEN: if (!is_space(c)) begin
        if (c == "{") phase = PH_T_KEY_OR_END; else raise(E_UNEXP);
      end
      PH_T_KEY_OR_END: if (!is_space(c)) begin
        if (c == "}") close_tensor();
        else if (c == "\"") begin key_live = 4'he; key_pos = 0; phase = PH_T_KEY; end
        else raise(E_UNEXP);
      end
      PH_T_KEY: begin
        if (c == "\"") phase = PH_T_COLON;
        else if (c == "\\") raise(E_ESC);
        else match_key(c);
      end
      PH_T_COLON: if (!is_space(c)) begin
        if (c != ":") raise(E_UNEXP);
        else if (key_hit(1)) phase = PH_DTYPE_OPEN;
        else if (key_hit(2)) phase = PH_SHAPE_OPEN;
        else if (key_hit(3)) phase = PH_OFF_OPEN;
        else begin skip_back = PH_T_AFTER; phase = PH_SKIP_START; end
      end
      PH_DTYPE_OPEN: if (!is_space(c)) begin
        if (c == "\"") begin dt_live = 13'h1fff; dt_pos = 0; phase = PH_DTYPE_STR; end
        else raise(E_UNEXP);
      end
      PH_DTYPE_STR: begin
        if (c == "\"") begin
          cur_dtype = dtype_pick(); fields_seen[0] = 1; phase = PH_T_AFTER;
        end else if (c == "\\") raise(E_ESC);
        else match_dtype(c);
      end
      PH_SHAPE_OPEN: if (!is_space(c)) begin
        if (c == "[") begin cur_rank = 0; phase = PH_SHAPE_FIRST; end else raise(E_UNEXP);
      end
      PH_SHAPE_FIRST: if (!is_space(c)) begin
        if (c == "]") begin fields_seen[1] = 1; phase = PH_T_AFTER; end
        else if (is_num(c)) begin accum = 64'(c - "0"); phase = PH_SHAPE_NUM; end
        else raise(E_NO_DIGIT);
      end
      PH_SHAPE_NUM: begin
        if (is_num(c)) accum = accum * 10 + 64'(c - "0");
        else begin
          emit(K_DIM);
          res.tensor_index = tensors_done[15:0];
          res.dim_index = cur_rank[2:0];
          res.dim_value = accum;
          cur_rank = cur_rank + 4'd1;
          phase = PH_SHAPE_SEP;
          again = 1;
        end
      end
      PH_SHAPE_SEP: if (!is_space(c)) begin
        if (c == ",") phase = cur_rank >= MaxRank ? PH_SHAPE_FULL : PH_SHAPE_ELEM;
        else if (c == "]") begin fields_seen[1] = 1; phase = PH_T_AFTER; end
        else raise(E_UNEXP);
      end
      PH_SHAPE_ELEM: if (!is_space(c)) begin
        if (is_num(c)) begin accum = 64'(c - "0"); phase = PH_SHAPE_NUM; end
        else raise(E_NO_DIGIT);
      end
      PH_SHAPE_FULL: raise(E_RANK);
      PH_OFF_OPEN: if (!is_space(c)) begin
        if (c == "[") phase = PH_OFF_A_PRE; else raise(E_UNEXP);
      end
      PH_OFF_A_PRE: if (!is_space(c)) begin
        if (is_num(c)) begin accum = 64'(c - "0"); phase = PH_OFF_A; end
        else raise(E_NO_DIGIT);
      end
      PH_OFF_A: begin
        if (is_num(c)) accum = accum * 10 + 64'(c - "0");
        else begin span_lo = accum; phase = PH_OFF_COMMA; again = 1; end
      end
      PH_OFF_COMMA: if (!is_space(c)) begin
        if (c == ",") phase = PH_OFF_B_PRE; else raise(E_UNEXP);
      end
      PH_OFF_B_PRE: if (!is_space(c)) begin
        if (is_num(c)) begin accum = 64'(c - "0"); phase = PH_OFF_B; end
        else raise(E_NO_DIGIT);
      end
      PH_OFF_B: begin
        if (is_num(c)) accum = accum * 10 + 64'(c - "0");
        else begin off_end = accum; phase = PH_OFF_CLOSE; again = 1; end
      end
      PH_OFF_CLOSE: if (!is_space(c)) begin
        if (c == "]") begin fields_seen[2] = 1; phase = PH_T_AFTER; end
        else raise(E_UNEXP);
      end
      PH_T_AFTER: if (!is_space(c)) begin
        if (c == ",") phase = PH_T_KEY_OR_END;
        else if (c == "}") close_tensor();
        else raise(E_UNEXP);
      end
      PH_TOP_AFTER: if (!is_space(c)) begin
        if (c == ",") phase = PH_TOP_KEY_OR_END;
        else if (c == "}") begin emit(K_DONE); phase = PH_DONE; end
        else raise(E_UNEXP);
      end
      PH_SKIP_START: if (!is_space(c)) begin
        if (c == "{" || c == "[") begin
          nest_square = c == "[";
          nest_depth = 1;
          phase = PH_SKIP_NEST;
        end else if (c == "\"") phase = PH_SKIP_STR;
        else if (c == "," || c == "]" || c == "}") begin phase = skip_back; again = 1; end
        else phase = PH_SKIP_SCALAR;
      end
      PH_SKIP_SCALAR:
        if (c == "," || c == "]" || c == "}" || is_space(c)) begin
          phase = skip_back; again = 1;
        end
      PH_SKIP_STR: begin
        if (c == "\"") phase = skip_back;
        else if (c == "\\") raise(E_ESC);
      end
      PH_SKIP_NEST: begin
        if (c == "\"") phase = PH_SKIP_NEST_STR;
        else if (c == open_ch) begin
          if (nest_depth >= DepthCap) raise(E_DEPTH); else nest_depth++;
        end else if (c == close_ch) begin
          nest_depth--;
          if (nest_depth == 0) phase = skip_back;
        end
      end
      PH_SKIP_NEST_STR: begin
        if (c == "\"") phase = PH_SKIP_NEST;
        else if (c == "\\") raise(E_ESC);
      end
      default: ;
    endcase
  endtask

  // full effect of one accepted request
  task automatic predict_request(logic [7:0] c, logic first, logic last);
    bit again;
    res_hit = 0;
    if (first) restart_parse();
    if (phase != PH_DONE && phase != PH_ERR) begin
      parse_byte(c, again);
      if (again) parse_byte(c, again);
    end
    if (last && phase != PH_DONE && phase != PH_ERR) raise(E_END);
    if (res_hit) expected_results.push_back(res);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      region_bytes = 0;
      restart_parse();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result kind %0d arrived with nothing expected", out_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("name_byte", want.name_byte, out_name_byte);
          check_field("tensor_index", want.tensor_index, out_tensor_index);
          check_field("dim_index", want.dim_index, out_dim_index);
          check_field("dim_value", want.dim_value, out_dim_value);
          check_field("dtype_code", want.dtype_code, out_dtype_code);
          check_field("element_bytes", want.element_bytes, out_element_bytes);
          check_field("rank", want.rank, out_rank);
          check_field("data_start", want.data_start, out_data_start);
          check_field("data_bytes", want.data_bytes, out_data_bytes);
          check_field("error_code", want.error_code, out_error_code);
        end
      end
      if (in_valid && in_ready) predict_request(in_header_byte, in_first_byte, in_last_byte);
      if (cfg_we) region_bytes = cfg_wdata;
    end
  end

endmodule

[tb/tensor_header_json_parser_tb.sv]
// testbench top for the tensor header parser: header stimulus, idling and verdict
`timescale 1ns / 100ps
module tensor_header_json_parser_tb;
  import thjp_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandomBytes = 1700;
  localparam logic [63:0] RegionMax = 64'hffff_ffff_ffff_ffff;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_header_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_name_byte;
  logic [15:0] out_tensor_index;
  logic [2:0]  out_dim_index;
  logic [63:0] out_dim_value;
  logic [3:0]  out_dtype_code;
  logic [3:0]  out_element_bytes;
  logic [3:0]  out_rank;
  logic [63:0] out_data_start;
  logic [63:0] out_data_bytes;
  logic [3:0]  out_error_code;
  int          fail_count;
  int          pending;
  int          cycles;
  int          sent_bytes;
  bit          calm;
  logic [63:0] region_now;
  logic [7:0]  hdr [$];

  string dtype_pool [17] = '{"F64", "F32", "F16", "BF16", "I64", "I32", "I16", "I8", "U64",
                             "U32", "U16", "U8", "BOOL", "F6", "BF1", "BOOLX", "q"};

  tensor_header_json_parser i_dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_header_byte,
    .in_first_byte, .in_last_byte, .out_valid, .out_ready, .out_kind, .out_name_byte,
    .out_tensor_index, .out_dim_index, .out_dim_value, .out_dtype_code,
    .out_element_bytes, .out_rank, .out_data_start, .out_data_bytes, .out_error_code
  );

  header_result_checker i_checker (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_header_byte,
    .in_first_byte, .in_last_byte, .out_valid, .out_ready, .out_kind, .out_name_byte,
    .out_tensor_index, .out_dim_index, .out_dim_value, .out_dtype_code,
    .out_element_bytes, .out_rank, .out_data_start, .out_data_bytes, .out_error_code,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk) out_ready <= calm || $urandom_range(0, 99) >= 17;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
  endtask

  task automatic put_ws();
    logic [7:0] pool [4] = '{" ", 8'h09, 8'h0a, 8'h0d};
    if ($urandom_range(0, 99) < 30)
      repeat ($urandom_range(1, 3)) hdr.push_back(pool[$urandom_range(0, 3)]);
  endtask

  task automatic put_dec(logic [63:0] v);
    logic [7:0] digits [$];
    if (v == 0) digits.push_back("0");
    while (v != 0) begin
      digits.push_front(8'("0" + v % 10));
      v = v / 10;
    end
    foreach (digits[i]) hdr.push_back(digits[i]);
  endtask

  // quoted key of random bytes, never a quote or a backslash
  task automatic put_name();
    logic [7:0] c;
    hdr.push_back("\"");
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
      hdr.push_back(c);
    end
    hdr.push_back("\"");
  endtask

  // a value that the parser only steps over
  task automatic put_skipped();
    case ($urandom_range(0, 5))
      0: put_str("\"a]}{,\"");
      1: put_str("{\"x\":{\"y\":[1,\"}\"]},\"z\":{}}");
      2: put_str("[1,[2,[]],\"]\",{\"k\":[]}]");
      3: put_dec(rand64());
      4: put_str("true");
      default: ;
    endcase
  endtask

  task automatic put_shape();
    int n;
    n = $urandom_range(0, 99) < 4 ? 9 : $urandom_range(0, 8);
    put_str("\"shape\"");
    put_ws();
    put_str(":[");
    for (int i = 0; i < n; i++) begin
      if (i != 0) begin put_ws(); put_str(","); end
      put_ws();
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(18, 25)) hdr.push_back(8'("0" + $urandom_range(0, 9)));
      else put_dec($urandom_range(0, 4096));
    end
    put_ws();
    put_str("]");
  endtask

  task automatic put_offsets();
    logic [63:0] a, b, t;
    b = region_now == RegionMax ? rand64() : rand64() % (region_now + 1);
    if ($urandom_range(0, 99) < 20) b = region_now;
    a = b == RegionMax ? rand64() : rand64() % (b + 1);
    if ($urandom_range(0, 99) < 8 && a != b) begin t = a; a = b; b = t; end
    else if ($urandom_range(0, 99) < 6 && region_now != RegionMax) b = region_now + 1;
    put_str({"\"data_", "offsets\""});
    put_ws();
    put_str(":[");
    put_ws();
    put_dec(a);
    put_ws();
    put_str(",");
    put_ws();
    put_dec(b);
    put_ws();
    put_str("]");
  endtask

  task automatic put_tensor();
    int order [4];
    int j, t, count;
    order = '{0, 1, 2, 3};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    put_name();
    put_ws();
    put_str(":");
    put_ws();
    put_str("{");
    count = 0;
    foreach (order[i]) begin
      if (order[i] == 3 ? $urandom_range(0, 99) < 20 : $urandom_range(0, 99) < 96) begin
        if (count != 0) begin put_ws(); put_str(","); end
        put_ws();
        case (order[i])
          0: begin
            put_str("\"dtype\"");
            put_ws();
            put_str(":\"");
            put_str(dtype_pool[$urandom_range(0, 99) < 88 ? $urandom_range(0, 12)
                                                         : $urandom_range(13, 16)]);
            put_str("\"");
          end
          1: put_shape();
          2: put_offsets();
          default: begin
            put_name();
            put_str(":");
            put_skipped();
          end
        endcase
        count++;
      end
    end
    if ($urandom_range(0, 99) < 8) begin put_str(","); put_shape(); end
    if (count != 0 && $urandom_range(0, 99) < 12) put_str(",");
    put_ws();
    put_str("}");
  endtask

  // a whole header, mostly well formed, with occasional faults and the odd damage
  task automatic build_header();
    int n, p;
    hdr.delete();
    put_ws();
    put_str("{");
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i != 0) put_str(",");
      put_ws();
      if ($urandom_range(0, 99) < 20) begin
        put_str("\"__metadata__\"");
        put_ws();
        put_str(":");
        put_ws();
        put_skipped();
      end else put_tensor();
      put_ws();
    end
    if (n != 0 && $urandom_range(0, 99) < 12) put_str(",");
    put_str("}");
    if ($urandom_range(0, 99) < 25) begin
      p = $urandom_range(0, hdr.size() - 1);
      case ($urandom_range(0, 2))
        0: hdr[p] = 8'($urandom_range(0, 255));
        1: while (hdr.size() > p + 1) void'(hdr.pop_back());
        default: hdr.insert(p, "\\");
      endcase
    end
    put_ws();
  endtask

  task automatic send_request(logic [7:0] b, logic first, logic last);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_header_byte <= b;
    in_first_byte <= first;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_header(bit mark_last);
    foreach (hdr[i]) send_request(hdr[i], i == 0, mark_last && i == hdr.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_region(logic [63:0] v);
    wait_drained();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    region_now = v;
  endtask

  task automatic send_text(string s);
    hdr.delete();
    put_str(s);
    send_header(1);
  endtask

  initial begin
    logic [63:0] regions [5];
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_header_byte = 0;
    in_first_byte = 0;
    in_last_byte = 0;
    out_ready = 0;
    calm = 0;
    sent_bytes = 0;
    region_now = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed headers
    set_region(64'd100);
    send_text("{}");
    send_text("x");
    send_text(" {\"a\\");
    send_text("{");
    send_text("{\"t\":{}}");
    send_text("{\"t\":{\"dtype\":\"BOOL\",\"shape\":[0,18446744073709551616],");
    send_text({"{\"w\":{\"dtype\":\"U8\",\"shape\":[],\"data_", "offsets\":[5,1]}}"});
    send_text({"{\"w\":{\"data_", "offsets\":[0,101],\"dtype\":\"I8\",\"shape\":[3,]}}"});
    send_text("{\"v\":{\"shape\":[1,2,3,4,5,6,7,8,9],\"dtype\":\"F16\",}}");

    // random headers over several region sizes
    regions = '{64'd0, RegionMax, 64'd1000, rand64() >> $urandom_range(0, 63), 64'd100};
    foreach (regions[k]) begin
      set_region(regions[k]);
      calm = k == 2;
      while (sent_bytes < RandomBytes * (k + 1) / 5) begin
        build_header();
        send_header($urandom_range(0, 99) < 90);
      end
    end
    calm = 0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[tensor_header_json_parser.f]
hw/rtl/thjp_pkg.sv
hw/rtl/thjp_matcher.sv
hw/rtl/tensor_header_json_parser.sv
tb/header_result_checker.sv
tb/tensor_header_json_parser_tb.sv
